@@ hdl/i2cdiv_pkg.sv @@
// i2cdiv_pkg: constants, sequencer states and the divisor table for the
// bus clock divider search. No dependencies; used by i2c_clock_divider_search.

package i2cdiv_pkg;

	// search space
	localparam int M_STEPS = 16;
	localparam int N_STEPS = 8;

	// field widths
	localparam int CLK_W  = 32;
	localparam int M_W    = 4;
	localparam int N_W    = 3;
	localparam int WORD_W = M_W + N_W;
	localparam int DIV_W  = 15;               // 10 * 16 * 2^7 = 20480 fits
	localparam int CNT_W  = $clog2(CLK_W);

	localparam logic [CLK_W-1:0] CLOCK_RESET = 32'd100000000;
	localparam int               BASE_DIV    = 10;
	localparam logic [M_W-1:0]   DEFAULT_M   = 4'd5;
	localparam logic [N_W-1:0]   DEFAULT_N   = 3'd0;

	localparam logic [M_W-1:0]   M_LAST   = M_W'(M_STEPS - 1);
	localparam logic [N_W-1:0]   N_LAST   = N_W'(N_STEPS - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CLK_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_EVAL,
		ST_FIN
	} state_t;

	// linear part of the divisor: 10 * (m + 1)
	function automatic logic [DIV_W-1:0] base_divisor(input logic [M_W-1:0] m);
		return DIV_W'(BASE_DIV * (int'(m) + 1));
	endfunction

endpackage

@@ hdl/i2c_clock_divider_search.sv @@
// i2c_clock_divider_search: picks the prescaler pair whose bus clock is the
// closest one not above the request. Depends on i2cdiv_pkg.
//
//  channel   dir  beat content
//  s_axis    in   tdata[31:0] target_rate_hz
//  m_axis    out  tdata[15:0] divider_word, divider_m, divider_n, no_fit
//  cfg_wr    in   cfg_wr_data[31:0] input_clock_hz
//
// 128 candidates, each one pass through a shared restoring divider
// (load state, quotient-bit states, compare state), then a finish state that
// waits until the output register is free. s_axis_tready is high only while
// the sequencer is idle.
// A finished result waits in the output register; a new item may be taken meanwhile.
// arst_n clears the sequencer, output valid and sets input_clock_hz to 100 MHz.

module i2c_clock_divider_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] target_rate_hz
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [6:0] divider_word, [10:7] divider_m,
	                                    // [13:11] divider_n, [14] no_fit, [15] zero
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data     // [31:0] input_clock_hz
);

	i2cdiv_pkg::state_t state_q, state_d;

	logic [i2cdiv_pkg::CLK_W-1:0] clk_hz_q;
	logic [i2cdiv_pkg::CLK_W-1:0] target_q;
	logic [i2cdiv_pkg::M_W-1:0]   m_q;
	logic [i2cdiv_pkg::N_W-1:0]   n_q;
	logic [i2cdiv_pkg::CNT_W-1:0] cnt_q;
	logic [i2cdiv_pkg::DIV_W-1:0] divisor_q;
	logic [i2cdiv_pkg::DIV_W-1:0] rem_q;
	logic [i2cdiv_pkg::CLK_W-1:0] quo_q;
	logic                         found_q;
	logic [i2cdiv_pkg::CLK_W-1:0] best_q;
	logic [i2cdiv_pkg::M_W-1:0]   sel_m_q;
	logic [i2cdiv_pkg::N_W-1:0]   sel_n_q;
	logic                         out_valid_q;
	logic [15:0]                  out_data_q;

	logic accept, last_cand, out_load;

	// divider step
	logic [i2cdiv_pkg::DIV_W:0]   trial;
	logic [i2cdiv_pkg::DIV_W:0]   trial_diff;
	logic                         trial_ge;

	// candidate compare
	logic [i2cdiv_pkg::CLK_W:0]   gap_full;
	logic                         fits;
	logic                         better;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign last_cand = (m_q == i2cdiv_pkg::M_LAST) && (n_q == i2cdiv_pkg::N_LAST);

	assign trial      = {rem_q, quo_q[i2cdiv_pkg::CLK_W-1]};
	assign trial_diff = trial - {1'b0, divisor_q};
	assign trial_ge   = !trial_diff[i2cdiv_pkg::DIV_W];

	assign gap_full = {1'b0, target_q} - {1'b0, quo_q};
	assign fits     = !gap_full[i2cdiv_pkg::CLK_W];
	assign better   = fits && (!found_q || (gap_full[i2cdiv_pkg::CLK_W-1:0] < best_q));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cdiv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			i2cdiv_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_d = i2cdiv_pkg::ST_LOAD;
			end
			i2cdiv_pkg::ST_LOAD: begin
				state_d = i2cdiv_pkg::ST_DIV;
			end
			i2cdiv_pkg::ST_DIV: begin
				if (cnt_q == i2cdiv_pkg::CNT_LAST) state_d = i2cdiv_pkg::ST_EVAL;
			end
			i2cdiv_pkg::ST_EVAL: begin
				state_d = last_cand ? i2cdiv_pkg::ST_FIN : i2cdiv_pkg::ST_LOAD;
			end
			i2cdiv_pkg::ST_FIN: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = i2cdiv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = i2cdiv_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= i2cdiv_pkg::CLOCK_RESET;
		end else if (cfg_wr_en) begin
			clk_hz_q <= cfg_wr_data;
		end
	end

	// search counters and best-so-far
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q     <= '0;
			n_q     <= '0;
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				i2cdiv_pkg::ST_IDLE: begin
					if (accept) begin
						m_q     <= '0;
						n_q     <= '0;
						found_q <= 1'b0;
					end
				end
				i2cdiv_pkg::ST_LOAD: begin
					cnt_q <= '0;
				end
				i2cdiv_pkg::ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
				end
				i2cdiv_pkg::ST_EVAL: begin
					if (better) found_q <= 1'b1;
					// m inner, n outer
					if (m_q == i2cdiv_pkg::M_LAST) begin
						m_q <= '0;
						n_q <= n_q + 1'b1;
					end else begin
						m_q <= m_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath: shared restoring divider and candidate compare
	always_ff @(posedge clk) begin
		case (state_q)
			i2cdiv_pkg::ST_IDLE: begin
				if (accept) target_q <= s_axis_tdata;
			end
			i2cdiv_pkg::ST_LOAD: begin
				divisor_q <= i2cdiv_pkg::base_divisor(m_q) << n_q;
				rem_q     <= '0;
				quo_q     <= clk_hz_q;
			end
			i2cdiv_pkg::ST_DIV: begin
				if (trial_ge) begin
					rem_q <= trial_diff[i2cdiv_pkg::DIV_W-1:0];
				end else begin
					rem_q <= trial[i2cdiv_pkg::DIV_W-1:0];
				end
				quo_q <= {quo_q[i2cdiv_pkg::CLK_W-2:0], trial_ge};
			end
			i2cdiv_pkg::ST_EVAL: begin
				if (better) begin
					best_q  <= gap_full[i2cdiv_pkg::CLK_W-1:0];
					sel_m_q <= m_q;
					sel_n_q <= n_q;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (found_q) begin
				out_data_q <= {1'b0, 1'b0, sel_n_q, sel_m_q, sel_m_q, sel_n_q};
			end else begin
				out_data_q <= {1'b0, 1'b1, i2cdiv_pkg::DEFAULT_N, i2cdiv_pkg::DEFAULT_M,
				               i2cdiv_pkg::DEFAULT_M, i2cdiv_pkg::DEFAULT_N};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// remainder stays below the divisor once the divider runs
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == i2cdiv_pkg::ST_DIV |-> rem_q < divisor_q)
		else $error("divider remainder not below divisor");

	// an accepted beat always starts a candidate load
	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == i2cdiv_pkg::ST_LOAD && m_q == '0 && n_q == '0)
		else $error("search did not start at the first pair");

	// a result is never overwritten while it waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || m_axis_tready)
		else $error("pending result overwritten");

	// packed word agrees with the separate fields
	a_word_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[6:0] == {m_axis_tdata[10:7], m_axis_tdata[13:11]})
		else $error("divider word does not match m and n");

	// no fit gives the default pair
	a_default_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[14] |->
			m_axis_tdata[10:7] == i2cdiv_pkg::DEFAULT_M &&
			m_axis_tdata[13:11] == i2cdiv_pkg::DEFAULT_N)
		else $error("no-fit result without default pair");

endmodule
